@@ rtl/gbm_path_step_antithetic_macros.svh @@
// ----------------------------------------------------------------------------
// gbm_path_step_antithetic_macros
// Assertion helpers for the assertions of the top-level module.
// ----------------------------------------------------------------------------
`ifndef GBM_PATH_STEP_ANTITHETIC_MACROS_SVH
`define GBM_PATH_STEP_ANTITHETIC_MACROS_SVH

// Same-cycle implication, idle during reset.
`define GBMPS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, idle during reset.
`define GBMPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/gbmps_pkg.sv @@
// ----------------------------------------------------------------------------
// gbmps_pkg
// Shared types, constants and the exp table of the GBM path stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package gbmps_pkg;

  localparam int EXP_TABLE_BITS    = 8;
  localparam int EXP_TABLE_ENTRIES = 1 << EXP_TABLE_BITS;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // Range reduction: k lives in [-64, 63] after an offset of 64*ln2.
  localparam int K_BITS   = 7;
  localparam int K_OFFSET = 1 << (K_BITS - 1);
  localparam int Q_BITS   = K_BITS + EXP_TABLE_BITS;
  localparam int XW       = 38;
  localparam int UW       = XW + 1;
  localparam int D_BITS   = 32 - EXP_TABLE_BITS;

  localparam logic [UW-1:0] U_OFFSET = UW'(K_OFFSET) * UW'(LN2_Q32);

  // Divide u*N by ln2 through a reciprocal: the top 32 bits of u times
  // floor(2^63 / ln2), shifted down, give the quotient or one less.
  localparam int          UNW       = UW + EXP_TABLE_BITS;
  localparam int          RCP_SHIFT = 63 - Q_BITS;
  localparam logic [31:0] RECIP_LN2 = 32'((64'd1 << 63) / 64'(LN2_Q32));

  localparam logic [31:0] START_PRICE_RESET = 32'd65536;

  typedef enum logic [2:0] {
    REG_START_PRICE = 3'd0,
    REG_DRIFT       = 3'd1,
    REG_VOL         = 3'd2,
    REG_PATH_LENGTH = 3'd3,
    REG_MODE        = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]        start_price;
    logic signed [31:0] drift_per_step;
    logic [30:0]        vol_per_step;
    logic [15:0]        path_length;
    logic               antithetic_mode;
  } cfg_t;

  typedef struct packed {
    logic signed [XW-1:0] x_main;
    logic signed [XW-1:0] x_mirror;
    logic [15:0]          step_index;
    logic                 path_last;
  } cmd_t;

  typedef struct packed {
    logic [31:0] price_main;
    logic [31:0] price_mirror;
    logic [15:0] step_index;
    logic        path_last;
    logic        saturated;
  } res_t;

  typedef logic [31:0] exp_tab_t [EXP_TABLE_ENTRIES];

  // exp(j*ln2/N) in Q2.30 from a 24-term series in Q.60, rounded half up
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t     tab;
    logic [127:0] s;
    logic [127:0] term;
    logic [127:0] sum;
    for (int j = 0; j < EXP_TABLE_ENTRIES; j++) begin
      s    = ((128'(j) * 128'(LN2_Q32)) >> EXP_TABLE_BITS) << 28;
      term = 128'(1) << 60;
      sum  = term;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * s) >> 60) / 128'(n);
        sum  = sum + term;
      end
      tab[j] = 32'((sum + (128'(1) << 29)) >> 30);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

@@ rtl/gbmps_front.sv @@
// ----------------------------------------------------------------------------
// gbmps_front
// Accepts samples, forms both log increments and tags step number and last.
// ----------------------------------------------------------------------------
`default_nettype none

module gbmps_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic signed [15:0]  normal_sample,
  input  gbmps_pkg::cfg_t     cfg,
  input  logic                cmd_full,
  output logic                cmd_push,
  output gbmps_pkg::cmd_t     cmd
);
  import gbmps_pkg::*;

  logic [15:0]        step_count;
  logic [15:0]        idx;
  logic               last;
  logic signed [31:0] vol_s;
  logic signed [47:0] base;
  logic signed [47:0] noise;
  logic signed [47:0] x_up;
  logic signed [47:0] x_dn;

  assign vol_s = $signed({1'b0, cfg.vol_per_step});
  assign base  = 48'(cfg.drift_per_step) <<< 14;
  assign noise = vol_s * normal_sample;
  assign x_up  = base + noise;
  assign x_dn  = base - noise;

  assign idx  = step_count + 16'd1;
  assign last = (idx >= cfg.path_length);

  assign cmd_push       = push && !cmd_full;
  assign cmd.x_main     = XW'(x_up >>> 10);
  assign cmd.x_mirror   = XW'(x_dn >>> 10);
  assign cmd.step_index = idx;
  assign cmd.path_last  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= 16'd0;
    end else if (cmd_push) begin
      step_count <= last ? 16'd0 : idx;
    end
  end

endmodule

`default_nettype wire

@@ rtl/gbmps_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// gbmps_cmd_fifo
// Two-word queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module gbmps_cmd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  gbmps_pkg::cmd_t wr_data,
  input  logic            rd,
  output gbmps_pkg::cmd_t rd_data,
  output logic            full,
  output logic            empty
);
  import gbmps_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) wr_ptr <= !wr_ptr;
      if (rd) rd_ptr <= !rd_ptr;
      count <= count + 2'(wr) - 2'(rd);
    end
  end

endmodule

`default_nettype wire

@@ rtl/gbmps_back.sv @@
// ----------------------------------------------------------------------------
// gbmps_back
// Scales the path prices by exp of each log increment and queues results.
// ----------------------------------------------------------------------------
`default_nettype none

module gbmps_back (
  input  logic            clk,
  input  logic            rst,
  input  gbmps_pkg::cfg_t cfg,
  input  logic            cmd_empty,
  input  gbmps_pkg::cmd_t cmd,
  output logic            cmd_pop,
  input  logic            res_pop,
  output logic            res_empty,
  output gbmps_pkg::res_t res
);
  import gbmps_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_RCP   = 9'b000000010,
    ST_REM   = 9'b000000100,
    ST_FIX   = 9'b000001000,
    ST_TAB   = 9'b000010000,
    ST_CORR  = 9'b000100000,
    ST_MANT  = 9'b001000000,
    ST_MUL   = 9'b010000000,
    ST_SHIFT = 9'b100000000
  } back_state_t;

  back_state_t               state;
  cmd_t                      item;
  logic                      sel_mirror;
  logic                      sat_acc;
  logic [UW-1:0]             u_r;
  logic [Q_BITS-1:0]         q_est;
  logic [32:0]               rem_r;
  logic [31:0]               div_rem;
  logic [Q_BITS-1:0]         div_dvd;
  logic signed [7:0]         k_r;
  logic [31:0]               entry_r;
  logic [D_BITS-1:0]         d_r;
  logic [D_BITS:0]           q2_r;
  logic [31:0]               m_r;
  logic [63:0]               prod_r;
  logic [31:0]               main_price;
  logic [31:0]               mirror_price;

  res_t                      omem [2];
  logic                      owr;
  logic                      ord;
  logic [1:0]                ocnt;
  logic                      res_push;
  res_t                      res_word;

  logic [63:0]               rcp_prod;
  logic [UNW-1:0]            rem_full;
  logic                      ge;
  logic [EXP_TABLE_BITS-1:0] j_q;
  logic [EXP_TABLE_BITS-1:0] low;
  logic [2*D_BITS-1:0]       dsq;
  logic [32+D_BITS:0]        ep;
  logic signed [7:0]         shift;
  logic [5:0]                ls;
  logic [63:0]               rsh;
  logic [63:0]               hi_part;
  logic [31:0]               new_price;
  logic                      new_sat;
  logic                      final_pass;

  // Division of u*N by ln2: high bits give k+offset, low bits give j.
  // Estimate by reciprocal, form the remainder, then fix up by one step.
  assign rcp_prod = 64'(u_r[UW-1:K_BITS]) * 64'(RECIP_LN2);
  assign rem_full = {u_r, {EXP_TABLE_BITS{1'b0}}} - UNW'(q_est) * UNW'(LN2_Q32);
  assign ge       = (rem_r >= 33'(LN2_Q32));
  assign j_q      = div_dvd[EXP_TABLE_BITS-1:0];
  assign low      = EXP_TABLE_BITS'(32'(j_q) * LN2_Q32);
  assign dsq      = d_r * d_r;
  assign ep       = entry_r * q2_r;

  // Scale by 2^k and clip.
  always_comb begin
    shift     = 8'sd30 - k_r;
    ls        = 6'd0;
    rsh       = 64'd0;
    hi_part   = 64'd0;
    new_price = 32'd0;
    new_sat   = 1'b0;
    if (shift >= 8'sd64) begin
      new_price = 32'd0;
    end else if (shift >= 8'sd0) begin
      rsh = prod_r >> shift[5:0];
      if (rsh[63:32] != 32'd0) begin
        new_price = 32'hFFFF_FFFF;
        new_sat   = 1'b1;
      end else begin
        new_price = rsh[31:0];
      end
    end else begin
      ls = 6'(-shift);
      hi_part = prod_r >> (6'd32 - ls);
      if (prod_r == 64'd0) begin
        new_price = 32'd0;
      end else if (ls >= 6'd32 || hi_part != 64'd0) begin
        new_price = 32'hFFFF_FFFF;
        new_sat   = 1'b1;
      end else begin
        new_price = 32'(prod_r << ls);
      end
    end
  end

  assign final_pass = (state == ST_SHIFT) && (sel_mirror || !cfg.antithetic_mode);
  assign res_push   = final_pass;
  assign cmd_pop    = (state == ST_IDLE) && !cmd_empty && (ocnt != 2'd2);

  always_comb begin
    res_word.price_main   = sel_mirror ? main_price : new_price;
    res_word.price_mirror = cfg.antithetic_mode ? new_price : 32'd0;
    res_word.step_index   = item.step_index;
    res_word.path_last    = item.path_last;
    res_word.saturated    = sat_acc || new_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sel_mirror   <= 1'b0;
      sat_acc      <= 1'b0;
      main_price   <= START_PRICE_RESET;
      mirror_price <= START_PRICE_RESET;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            item       <= cmd;
            sel_mirror <= 1'b0;
            sat_acc    <= 1'b0;
            u_r        <= UW'(cmd.x_main) + U_OFFSET;
            state      <= ST_RCP;
          end
        end
        ST_RCP: begin
          q_est <= Q_BITS'(rcp_prod >> RCP_SHIFT);
          state <= ST_REM;
        end
        ST_REM: begin
          rem_r <= 33'(rem_full);
          state <= ST_FIX;
        end
        ST_FIX: begin
          // the estimate is low by at most one
          if (ge) begin
            div_dvd <= q_est + 1'b1;
            div_rem <= 32'(rem_r - 33'(LN2_Q32));
          end else begin
            div_dvd <= q_est;
            div_rem <= rem_r[31:0];
          end
          state <= ST_TAB;
        end
        ST_TAB: begin
          k_r     <= 8'(div_dvd[Q_BITS-1:EXP_TABLE_BITS]) - 8'(K_OFFSET);
          entry_r <= EXP_TAB[j_q];
          d_r     <= D_BITS'((33'(div_rem) + 33'(low)) >> EXP_TABLE_BITS);
          state   <= ST_CORR;
        end
        ST_CORR: begin
          q2_r  <= (D_BITS+1)'(d_r) + (D_BITS+1)'(dsq >> 33);
          state <= ST_MANT;
        end
        ST_MANT: begin
          m_r   <= entry_r + 32'(ep >> 32);
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod_r <= (sel_mirror ? mirror_price : main_price) * m_r;
          state  <= ST_SHIFT;
        end
        ST_SHIFT: begin
          sat_acc <= sat_acc || new_sat;
          if (final_pass && item.path_last) begin
            // reload both paths after the last step
            main_price   <= cfg.start_price;
            mirror_price <= cfg.start_price;
          end else if (sel_mirror) begin
            mirror_price <= new_price;
          end else begin
            main_price <= new_price;
          end
          if (final_pass) begin
            state <= ST_IDLE;
          end else begin
            sel_mirror <= 1'b1;
            u_r        <= UW'(item.x_mirror) + U_OFFSET;
            state      <= ST_RCP;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result queue
  assign res_empty = (ocnt == 2'd0);
  assign res       = omem[ord];

  always_ff @(posedge clk) begin
    if (res_push) begin
      omem[owr] <= res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr  <= 1'b0;
      ord  <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      if (res_push) owr <= !owr;
      if (res_pop && !res_empty) ord <= !ord;
      ocnt <= ocnt + 2'(res_push) - 2'(res_pop && !res_empty);
    end
  end

endmodule

`default_nettype wire

@@ rtl/gbm_path_step_antithetic.sv @@
// ----------------------------------------------------------------------------
// gbm_path_step_antithetic
// Geometric Brownian motion path stepper with an optional antithetic twin.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Word
//  --------  ---------------------  ------------------------------------------
//  sample    push / full            normal_sample
//  result    pop / empty            price_main, price_mirror, step_index,
//                                   path_last, saturated
//  config    cfg_write              cfg_index, cfg_data
//
//  The back takes a word from the queue, then for each price (main only with
//  antithetic mode off, main then mirror with it on) runs a reciprocal
//  multiply, a remainder and a one-step fix-up of the divide by ln2, table
//  read, correction, mantissa, price multiply and shift, each in its own state.
//  The front takes a new word every cycle while the two-word command queue has
//  room; the two-word result queue lets the back finish while results wait.
//  Reset is synchronous and clears queues, step count and prices (to 1.0).
// ----------------------------------------------------------------------------
`default_nettype none

`include "gbm_path_step_antithetic_macros.svh"

module gbm_path_step_antithetic (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] normal_sample,
  input  logic               pop,
  output logic               empty,
  output logic [31:0]        price_main,
  output logic [31:0]        price_mirror,
  output logic [15:0]        step_index,
  output logic               path_last,
  output logic               saturated,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import gbmps_pkg::*;

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t queue_cmd;
  res_t res;
  logic cmd_push;
  logic cmd_pop;
  logic cmd_empty;

  // Hold configuration; drop writes to unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_price     <= START_PRICE_RESET;
      cfg.drift_per_step  <= 32'sd0;
      cfg.vol_per_step    <= 31'd0;
      cfg.path_length     <= 16'd1;
      cfg.antithetic_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_PRICE: cfg.start_price     <= cfg_data;
        REG_DRIFT:       cfg.drift_per_step  <= $signed(cfg_data);
        REG_VOL:         cfg.vol_per_step    <= cfg_data[30:0];
        REG_PATH_LENGTH: cfg.path_length     <= cfg_data[15:0];
        REG_MODE:        cfg.antithetic_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Front: form log increments and tag step number and last.
  gbmps_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .normal_sample (normal_sample),
    .cfg           (cfg),
    .cmd_full      (full),
    .cmd_push      (cmd_push),
    .cmd           (front_cmd)
  );

  // Decouple front and back.
  gbmps_cmd_fifo u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_push),
    .wr_data (front_cmd),
    .rd      (cmd_pop),
    .rd_data (queue_cmd),
    .full    (full),
    .empty   (cmd_empty)
  );

  // Back: advance prices and queue results.
  gbmps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (queue_cmd),
    .cmd_pop   (cmd_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign price_main   = res.price_main;
  assign price_mirror = res.price_mirror;
  assign step_index   = res.step_index;
  assign path_last    = res.path_last;
  assign saturated    = res.saturated;

  // A saturated word carries a clipped price.
  `GBMPS_ASSERT_NOW(a_sat_clipped, clk, rst, !empty && saturated,
    price_main == 32'hFFFF_FFFF || price_mirror == 32'hFFFF_FFFF)
  // Mirror price reads zero with the twin path off.
  `GBMPS_ASSERT_NOW(a_mirror_off, clk, rst, !empty && !cfg.antithetic_mode,
    price_mirror == 32'd0)
  // Step numbers start at one.
  `GBMPS_ASSERT_NOW(a_step_nonzero, clk, rst, !empty, step_index != 16'd0)

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the GBM path stepper
// Drives normal samples through the push/full side and register writes
// between phases, predicts each result word from its own fixed-point model
// of the exp scaling, and checks every popped word field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import gbmps_pkg::*;

  localparam longint LN2 = 64'd2977044472;
  localparam longint LO32 = 64'hFFFF_FFFF;
  localparam int TAB_N = 256;
  // indexes the block has no register for
  localparam logic [2:0] REG_NONE_LO = 3'd5;
  localparam logic [2:0] REG_NONE_HI = 3'd7;
  // cycles of quiet before a register write
  localparam int SETTLE_CYCLES = 60;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic signed [15:0] normal_sample = '0;
  logic               pop = 1'b0;
  logic               empty;
  logic [31:0]        price_main;
  logic [31:0]        price_mirror;
  logic [15:0]        step_index;
  logic               path_last;
  logic               saturated;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  gbm_path_step_antithetic i_dut (
    .clk, .rst, .push, .full, .normal_sample, .pop, .empty,
    .price_main, .price_mirror, .step_index, .path_last, .saturated,
    .cfg_write, .cfg_index, .cfg_data
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one pending entry: either a sample word or a register write
  typedef struct {
    bit                 is_cfg;
    logic [2:0]         idx;
    logic [31:0]        data;
    logic signed [15:0] sample;
  } pend_t;

  pend_t pend_q[$];
  res_t  exp_words[$];
  int    errors = 0;

  // ---------------- price model ----------------
  logic [31:0] exp_lut [TAB_N];
  logic [31:0] m_start = 32'd65536;
  longint      m_drift = 0;
  longint      m_vol = 0;
  logic [15:0] m_len = 16'd1;
  bit          m_anti = 1'b0;
  logic [31:0] m_main = 32'd65536;
  logic [31:0] m_mirror = 32'd65536;
  logic [15:0] m_steps = '0;

  // exp(j*ln2/N) in Q2.30 from a 24-term Taylor sum in Q.60
  task automatic fill_exp_lut();
    logic [127:0] s, term, sum;
    for (int j = 0; j < TAB_N; j++) begin
      s    = (128'((longint'(j) * LN2) / TAB_N)) << 28;
      term = 128'(1) << 60;
      sum  = term;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * s) >> 60) / 128'(n);
        sum  = sum + term;
      end
      exp_lut[j] = 32'((sum + (128'(1) << 29)) >> 30);
    end
  endtask

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  // price * exp(xq / 2^42), clipped at all ones
  function automatic logic [31:0] grow_price(logic [31:0] price, longint xq, inout bit sat);
    longint x, k, r, j, s, d, sh;
    logic [127:0] p, m, prod, res;
    x  = xq >>> 10;
    k  = floor_quot(x, LN2);
    r  = x - k * LN2;
    j  = (r * TAB_N) / LN2;
    if (j < 0) j = 0;
    if (j >= TAB_N) j = TAB_N - 1;
    s  = (j * LN2) / TAB_N;
    d  = r - s;
    p  = (128'(1) << 32) + 128'(d) + ((128'(d) * 128'(d)) >> 33);
    m  = (128'(exp_lut[j]) * p) >> 32;
    prod = 128'(price) * m;
    sh = 30 - k;
    if (sh >= 64) return 32'd0;
    if (sh >= 0) begin
      res = prod >> sh;
      if (res > 128'(LO32)) begin
        sat = 1'b1;
        return 32'hFFFF_FFFF;
      end
      return 32'(res);
    end
    if (prod == 0) return 32'd0;
    if (-sh >= 32 || prod > 128'(LO32 >> (-sh))) begin
      sat = 1'b1;
      return 32'hFFFF_FFFF;
    end
    return 32'(prod << (-sh));
  endfunction

  task automatic apply_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      REG_START_PRICE: m_start = data;
      REG_DRIFT:       m_drift = longint'(signed'(data));
      REG_VOL:         m_vol = longint'({33'd0, data[30:0]});
      REG_PATH_LENGTH: m_len = data[15:0];
      REG_MODE:        m_anti = data[0];
      default: ;
    endcase
  endtask

  task automatic step_path(logic signed [15:0] z);
    longint base, noise;
    bit sat;
    res_t w;
    logic [15:0] idx;
    sat   = 1'b0;
    base  = m_drift * 16384;
    noise = m_vol * longint'(z);
    m_main = grow_price(m_main, base + noise, sat);
    w.price_mirror = '0;
    if (m_anti) begin
      m_mirror = grow_price(m_mirror, base - noise, sat);
      w.price_mirror = m_mirror;
    end
    idx = m_steps + 16'd1;
    w.price_main = m_main;
    w.step_index = idx;
    w.path_last  = (idx >= m_len);
    w.saturated  = sat;
    exp_words.insert(exp_words.size(), w);
    if (w.path_last) begin
      m_main   = m_start;
      m_mirror = m_start;
      m_steps  = '0;
    end else begin
      m_steps = idx;
    end
  endtask

  // ---------------- stimulus helpers ----------------
  task automatic add_reg(logic [2:0] idx, logic [31:0] data);
    pend_t e;
    e.is_cfg = 1'b1; e.idx = idx; e.data = data; e.sample = '0;
    pend_q.insert(pend_q.size(), e);
  endtask

  task automatic add_word(logic signed [15:0] z);
    pend_t e;
    e.is_cfg = 1'b0; e.idx = '0; e.data = '0; e.sample = z;
    pend_q.insert(pend_q.size(), e);
  endtask

  // mostly short gaps, a few long, none while a burst phase is on
  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // ---------------- driver ----------------
  int in_gap = 0;
  int quiet = 0;
  bit in_burst = 1'b0;

  always @(posedge clk) begin
    bit taken;
    bit do_cfg;
    if (rst) begin
      push <= 1'b0;
      cfg_write <= 1'b0;
    end else begin
      taken  = push && !full;
      do_cfg = 1'b0;
      if (taken) begin
        step_path(normal_sample);
        void'(pend_q.pop_front());
      end
      if ($urandom_range(0, 199) == 0) in_burst <= !in_burst;

      if (push && !taken) begin
        // hold the word until the block takes it
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        push <= 1'b0;
      end else if (pend_q.size() > 0 && !pend_q[0].is_cfg) begin
        push <= 1'b1;
        normal_sample <= pend_q[0].sample;
        in_gap <= pick_gap(in_burst);
      end else begin
        push <= 1'b0;
        if (pend_q.size() > 0 && !taken && exp_words.size() == 0 &&
            quiet >= SETTLE_CYCLES) begin
          do_cfg = 1'b1;
          cfg_index <= pend_q[0].idx;
          cfg_data  <= pend_q[0].data;
          apply_reg(pend_q[0].idx, pend_q[0].data);
          void'(pend_q.pop_front());
        end
      end
      cfg_write <= do_cfg;
      // count quiet cycles so a write lands only when the block is idle
      if (!do_cfg && exp_words.size() == 0 && !push) quiet <= quiet + 1;
      else quiet <= 0;
    end
  end

  // ---------------- monitor ----------------
  int out_gap = 0;
  int hold_off = 0;
  int words_seen = 0;

  always @(posedge clk) begin
    res_t w;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        words_seen <= words_seen + 1;
        if (exp_words.size() == 0) begin
          $error("result word with nothing expected: main %h", price_main);
          errors++;
        end else begin
          w = exp_words.pop_front();
          if (price_main !== w.price_main) begin
            $error("price_main expected %h actual %h", w.price_main, price_main); errors++;
          end
          if (price_mirror !== w.price_mirror) begin
            $error("price_mirror expected %h actual %h", w.price_mirror, price_mirror);
            errors++;
          end
          if (step_index !== w.step_index) begin
            $error("step_index expected %0d actual %0d", w.step_index, step_index); errors++;
          end
          if (path_last !== w.path_last) begin
            $error("path_last expected %b actual %b", w.path_last, path_last); errors++;
          end
          if (saturated !== w.saturated) begin
            $error("saturated expected %b actual %b", w.saturated, saturated); errors++;
          end
        end
      end
      // one long hold-off so the queues fill and full backs up the sender
      if (words_seen == 150 && pop && !empty) begin
        hold_off <= 400;
        pop <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        pop <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        out_gap <= pick_gap(1'b0);
      end
    end
  end

  // ---------------- test sequence ----------------
  function automatic logic signed [15:0] gauss_ish();
    // sum of uniforms, roughly N(0,1) in Q4.12
    int acc;
    acc = 0;
    for (int i = 0; i < 4; i++) acc += $urandom_range(0, 7094) - 3547;
    return 16'(acc);
  endfunction

  initial begin
    logic signed [15:0] z;
    int nwords;
    fill_exp_lut();

    // directed: defaults first, then extremes of samples and registers
    add_word(16'sh7FFF);
    add_word(-16'sh8000);
    add_reg(REG_VOL, 32'h7FFF_FFFF);
    add_reg(REG_MODE, 32'd1);
    add_reg(REG_PATH_LENGTH, 32'd4);
    add_word(16'sh7FFF);              // drives the main price to its clip
    add_word(16'sh7FFF);              // stays clipped and scales from there
    add_word(-16'sh8000);
    add_word(16'sd0);
    add_reg(REG_START_PRICE, 32'd0);  // zero start price, replaced before the next reload
    add_reg(REG_VOL, 32'd0);
    add_reg(REG_DRIFT, 32'h7FFF_FFFF);
    add_word(16'sd1);
    add_word(-16'sd1);
    add_reg(REG_DRIFT, 32'h8000_0000);
    add_reg(REG_START_PRICE, 32'hFFFF_FFFF);
    add_word(16'sd0);
    add_word(16'sd0);
    add_reg(REG_NONE_LO, 32'hDEAD_BEEF);
    add_reg(REG_NONE_HI, 32'h1234_5678);
    add_reg(REG_DRIFT, 32'h0010_0000);
    add_reg(REG_VOL, 32'h0400_0000);
    add_reg(REG_PATH_LENGTH, 32'd10);
    add_word(16'sd4096);
    add_reg(REG_MODE, 32'd0);         // mode off mid-path: mirror holds
    add_word(-16'sd4096);
    add_reg(REG_MODE, 32'd1);         // resume mirror from held value
    add_word(16'sd2000);
    add_reg(REG_START_PRICE, 32'h0001_8000); // applies at next reload
    add_reg(REG_PATH_LENGTH, 32'd2);  // below steps done: next is last
    add_word(16'sd100);
    add_reg(REG_PATH_LENGTH, 32'd0);  // zero acts as one
    add_word(-16'sd100);
    add_word(16'sd300);

    // random phases: mostly sane market settings, some extremes
    nwords = 0;
    while (nwords < 1100) begin
      if ($urandom_range(0, 4) == 0) begin
        add_reg(REG_START_PRICE, $urandom());
        add_reg(REG_DRIFT, $urandom());
        add_reg(REG_VOL, $urandom());
        add_reg(REG_PATH_LENGTH, $urandom_range(0, 3) == 0 ? 32'd65535 : $urandom());
      end else begin
        add_reg(REG_START_PRICE, $urandom_range(32'h0000_4000, 32'h0100_0000));
        add_reg(REG_DRIFT, 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
        add_reg(REG_VOL, $urandom_range(0, 32'h0800_0000));
        add_reg(REG_PATH_LENGTH, $urandom_range(1, 40));
      end
      add_reg(REG_MODE, $urandom());
      repeat ($urandom_range(60, 140)) begin
        z = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : gauss_ish();
        add_word(z);
        nwords++;
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pend_q.size() == 0 && exp_words.size() == 0 && !push);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && exp_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #1500000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
